FILE: rtl/pcx_rle_plane_decoder_unit_assert.svh
// Assertion macros for the PCX run-length plane decoder.
// Depends on nothing; included by the top level of the decoder.
`ifndef PCX_RLE_PLANE_DECODER_UNIT_ASSERT_SVH
`define PCX_RLE_PLANE_DECODER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define PCX_RLE_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcx_rle: same-cycle property failed");

// Next-cycle implication, disabled while reset is high.
`define PCX_RLE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcx_rle: next-cycle property failed");

`endif

FILE: rtl/pcx_rle_pkg.sv
// Shared constants, types and helper functions of the PCX run-length plane decoder.
// Depends on nothing; used by every other file of the decoder but the assertion header.
`default_nettype none
package pcx_rle_pkg;

   localparam int MaxWidth   = 4096;
   localparam int StoreDepth = MaxWidth + 7;
   localparam int Lanes      = 8;
   localparam int LaneW      = 8;
   localparam int GroupW     = Lanes * LaneW;
   localparam int RamWords   = (StoreDepth + Lanes - 1) / Lanes;
   localparam int RamAddrW   = $clog2(RamWords);
   localparam int ColW       = $clog2(StoreDepth);
   localparam int CsrIndexW  = 3;
   localparam int CsrDataW   = 17;

   localparam logic [1:0] RunMarkerHi = 2'b11;
   localparam logic [3:0] PadLimit    = 4'd7;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_BITS_PER_PIXEL = 3'd0,
      CSR_PLANE_COUNT    = 3'd1,
      CSR_BYTES_PER_LINE = 3'd2,
      CSR_IMAGE_WIDTH    = 3'd3,
      CSR_IMAGE_HEIGHT   = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_APPLY,
      ST_ERROR
   } decode_state_type;

   typedef struct packed {
      logic [1:0]      log_depth;
      logic [2:0]      last_plane;
      logic [15:0]     bytes_per_line;
      logic [ColW-1:0] image_width;
      logic [16:0]     image_height;
      logic            setting_bad;
      logic            restart;
   } cfg_type;

   typedef struct packed {
      logic                rd_en;
      logic [RamAddrW-1:0] rd_addr;
      logic                wr_en;
      logic [Lanes-1:0]    wr_lanes;
      logic [RamAddrW-1:0] wr_addr;
      logic [GroupW-1:0]   wr_data;
   } ram_req_type;

   typedef struct packed {
      logic active;
      logic finished;
   } status_type;

   typedef struct packed {
      logic [GroupW-1:0] pixel_group;
      logic [3:0]        pixel_count;
      logic [15:0]       row_index;
      logic [11:0]       first_column;
      logic              row_last;
      logic              image_last;
      logic              setting_bad;
   } rsp_type;

   // Splits a coded byte into its pixel fields, most significant field first,
   // one field per byte lane starting at lane 0.
   function automatic logic [GroupW-1:0] pixel_fields(input logic [7:0] code,
                                                      input logic [1:0] log_depth);
      logic [GroupW-1:0] fields;
      logic [3:0]        depth;
      logic [3:0]        ppb;
      logic [7:0]        fmask;
      logic [7:0]        shifted;
      int                k;
      fields = '0;
      depth  = 4'd1 << log_depth;
      ppb    = 4'd8 >> log_depth;
      fmask  = 8'((9'd1 << depth) - 9'd1);
      for (k = 0; k < Lanes; k++) begin
         if (4'(k) < ppb) begin
            shifted = code >> (4'd8 - 4'(depth * (4'(k) + 4'd1)));
            fields[k*LaneW +: LaneW] = shifted & fmask;
         end
      end
      return fields;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/pcx_rle_ifs.sv
// Channel interfaces of the PCX run-length plane decoder: coded bytes in,
// pixel groups out, and register writes. Depends on pcx_rle_pkg.
`default_nettype none
interface pcx_rle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] code_byte;
   modport source (output valid, output code_byte, input ready);
   modport sink (input valid, input code_byte, output ready);
endinterface

interface pcx_rle_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [pcx_rle_pkg::GroupW-1:0] pixel_group;
   logic [3:0]                     pixel_count;
   logic [15:0]                    row_index;
   logic [11:0]                    first_column;
   logic                           row_last;
   logic                           image_last;
   logic                           setting_bad;
   modport source (output valid, output pixel_group, output pixel_count,
                   output row_index, output first_column, output row_last,
                   output image_last, output setting_bad, input ready);
   modport sink (input valid, input pixel_group, input pixel_count,
                 input row_index, input first_column, input row_last,
                 input image_last, input setting_bad, output ready);
endinterface

interface pcx_rle_csr_if;
   logic                                valid;
   logic                                ready;
   logic [pcx_rle_pkg::CsrIndexW-1:0]   index;
   logic [pcx_rle_pkg::CsrDataW-1:0]    data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/pcx_rle_plane_decoder_unit.sv
// Top level of the PCX run-length plane decoder: registers, decode sequencer
// and line store. Depends on pcx_rle_pkg, pcx_rle_ifs, pcx_rle_csr,
// pcx_rle_line_ram, pcx_rle_core and pcx_rle_plane_decoder_unit_assert.svh.
//
//  Channel  Direction  Transaction payload
//  req_if   in         code_byte[7:0]
//  rsp_if   out        pixel_group[63:0], pixel_count, row_index, first_column,
//                      row_last, image_last, setting_bad
//  csr_if   in         index[2:0], data[16:0]
//
// Each decoded byte repetition goes straight to the merge in plane 0; in later
// planes the line RAM read in ST_FETCH comes before the merge in ST_APPLY.
// A run marker or an ignored byte is accepted without a decode step; a run of
// n repeats holds the input for n repetitions. The result register stalls
// decoding only while it holds an untaken transaction. Reset and every write to a
// known register index return the decoder to row 0, plane 0; the line RAM needs no clearing pass.
`default_nettype none
`include "pcx_rle_plane_decoder_unit_assert.svh"
module pcx_rle_plane_decoder_unit (
   input  logic          clock,
   input  logic          reset,
   pcx_rle_req_if.sink   req_if,
   pcx_rle_rsp_if.source rsp_if,
   pcx_rle_csr_if.sink   csr_if
);

   pcx_rle_pkg::cfg_type                cfg;
   pcx_rle_pkg::ram_req_type            ram_req;
   pcx_rle_pkg::status_type             status;
   logic [pcx_rle_pkg::GroupW-1:0]      ram_rdata;

   pcx_rle_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_if (csr_if),
      .cfg    (cfg)
   );

   pcx_rle_line_ram u_line_ram (
      .clock (clock),
      .req   (ram_req),
      .rdata (ram_rdata)
   );

   pcx_rle_core u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .req_if    (req_if),
      .rsp_if    (rsp_if),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata),
      .status    (status)
   );

   `PCX_RLE_ASSERT_IMPLY(a_error_result_empty, clock, reset, rsp_if.valid && rsp_if.setting_bad, rsp_if.pixel_count == 4'd0 && rsp_if.pixel_group == '0 && !rsp_if.row_last)
   `PCX_RLE_ASSERT_IMPLY(a_group_not_empty, clock, reset, rsp_if.valid && !rsp_if.setting_bad, rsp_if.pixel_count != 4'd0 && rsp_if.pixel_count <= 4'd8)
   `PCX_RLE_ASSERT_IMPLY(a_image_end_is_row_end, clock, reset, rsp_if.valid && rsp_if.image_last, rsp_if.row_last)
   `PCX_RLE_ASSERT_NEXT(a_restart_clears, clock, reset, cfg.restart, !status.active && !status.finished)

endmodule
`default_nettype wire

FILE: rtl/pcx_rle_csr.sv
// Configuration registers of the PCX run-length plane decoder, with the
// derived depth, plane, height and setting check. Depends on pcx_rle_pkg.
`default_nettype none
module pcx_rle_csr (
   input  logic                 clock,
   input  logic                 reset,
   pcx_rle_csr_if.sink          csr_if,
   output pcx_rle_pkg::cfg_type cfg
);

   logic [3:0]                   bpp_ff, bpp_in;
   logic [3:0]                   planes_ff, planes_in;
   logic [15:0]                  bpl_ff, bpl_in;
   logic [pcx_rle_pkg::ColW-1:0] width_ff, width_in;
   logic [16:0]                  height_ff, height_in;
   logic                         write;
   logic                         known;
   logic [1:0]                   log_depth;
   logic [1:0]                   log_ppb;
   logic [18:0]                  span;
   logic [18:0]                  width_ext;

   assign csr_if.ready = 1'b1;
   assign write = csr_if.valid && csr_if.ready;

   always_comb begin
      bpp_in    = bpp_ff;
      planes_in = planes_ff;
      bpl_in    = bpl_ff;
      width_in  = width_ff;
      height_in = height_ff;
      known     = 1'b1;
      unique case (csr_if.index)
         pcx_rle_pkg::CSR_BITS_PER_PIXEL: bpp_in    = csr_if.data[3:0];
         pcx_rle_pkg::CSR_PLANE_COUNT:    planes_in = csr_if.data[3:0];
         pcx_rle_pkg::CSR_BYTES_PER_LINE: bpl_in    = csr_if.data[15:0];
         pcx_rle_pkg::CSR_IMAGE_WIDTH:    width_in  = csr_if.data[pcx_rle_pkg::ColW-1:0];
         pcx_rle_pkg::CSR_IMAGE_HEIGHT:   height_in = csr_if.data[16:0];
         default:                         known     = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff    <= 4'd8;
         planes_ff <= 4'd1;
         bpl_ff    <= 16'd1;
         width_ff  <= pcx_rle_pkg::ColW'(1);
         height_ff <= 17'd1;
      end else if (write) begin
         bpp_ff    <= bpp_in;
         planes_ff <= planes_in;
         bpl_ff    <= bpl_in;
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      unique case (bpp_ff)
         4'd1:    log_depth = 2'd0;
         4'd2:    log_depth = 2'd1;
         4'd4:    log_depth = 2'd2;
         default: log_depth = 2'd3;
      endcase
   end

   assign log_ppb   = 2'd3 - log_depth;
   assign span      = {3'b000, bpl_ff} << log_ppb;
   assign width_ext = 19'(width_ff);

   always_comb begin
      cfg.log_depth      = log_depth;
      cfg.bytes_per_line = bpl_ff;
      cfg.image_width    = width_ff;
      cfg.restart        = write && known;
      priority if (planes_ff == 4'd0) begin
         cfg.last_plane = 3'd0;
      end else if (planes_ff > 4'd8) begin
         cfg.last_plane = 3'd7;
      end else begin
         cfg.last_plane = 3'(planes_ff - 4'd1);
      end
      priority if (height_ff == 17'd0) begin
         cfg.image_height = 17'd1;
      end else if (height_ff > 17'd65536) begin
         cfg.image_height = 17'd65536;
      end else begin
         cfg.image_height = height_ff;
      end
      cfg.setting_bad = (width_ff == '0)
                     || (width_ff > pcx_rle_pkg::ColW'(pcx_rle_pkg::MaxWidth))
                     || (span < width_ext)
                     || ((span - width_ext) > 19'(pcx_rle_pkg::PadLimit));
   end

endmodule
`default_nettype wire

FILE: rtl/pcx_rle_line_ram.sv
// Line store of the PCX run-length plane decoder: one word of eight pixel
// bytes per entry, byte-lane writes, registered read. Depends on pcx_rle_pkg.
`default_nettype none
module pcx_rle_line_ram (
   input  logic                                 clock,
   input  pcx_rle_pkg::ram_req_type             req,
   output logic [pcx_rle_pkg::GroupW-1:0]       rdata
);

   logic [pcx_rle_pkg::GroupW-1:0] mem_ff [pcx_rle_pkg::RamWords];
   logic [pcx_rle_pkg::GroupW-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         for (int j = 0; j < pcx_rle_pkg::Lanes; j++) begin
            if (req.wr_lanes[j]) begin
               mem_ff[req.wr_addr][j*pcx_rle_pkg::LaneW +: pcx_rle_pkg::LaneW] <=
                  req.wr_data[j*pcx_rle_pkg::LaneW +: pcx_rle_pkg::LaneW];
            end
         end
      end
      if (req.rd_en) begin
         rdata_ff <= mem_ff[req.rd_addr];
      end
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

FILE: rtl/pcx_rle_core.sv
// Decode sequencer of the PCX run-length plane decoder: run handling, line
// position counters, read-modify-write of the line store and the result register.
// Depends on pcx_rle_pkg and pcx_rle_ifs.
`default_nettype none
module pcx_rle_core (
   input  logic                                clock,
   input  logic                                reset,
   input  pcx_rle_pkg::cfg_type                cfg,
   pcx_rle_req_if.sink                         req_if,
   pcx_rle_rsp_if.source                       rsp_if,
   output pcx_rle_pkg::ram_req_type            ram_req,
   input  logic [pcx_rle_pkg::GroupW-1:0]      ram_rdata,
   output pcx_rle_pkg::status_type             status
);

   localparam int Lanes = pcx_rle_pkg::Lanes;
   localparam int LaneW = pcx_rle_pkg::LaneW;
   localparam int ColW  = pcx_rle_pkg::ColW;

   pcx_rle_pkg::decode_state_type state_ff, state_in;
   logic [7:0]  byte_ff, byte_in;
   logic [5:0]  reps_ff, reps_in;
   logic [15:0] bil_ff, bil_in;
   logic [2:0]  plane_ff, plane_in;
   logic [16:0] row_ff, row_in;
   logic        run_pending_ff, run_pending_in;
   logic [5:0]  run_length_ff, run_length_in;
   logic        finished_ff, finished_in;
   logic        out_valid_ff, out_valid_in;
   pcx_rle_pkg::rsp_type out_ff, out_in;

   logic [1:0]                       log_ppb;
   logic [3:0]                       ppb;
   logic [18:0]                      col_wide;
   logic [ColW-1:0]                  col;
   logic [2:0]                       lane0;
   logic [pcx_rle_pkg::RamAddrW-1:0] word_addr;
   logic [5:0]                       shift;
   logic                             last_plane;
   logic [pcx_rle_pkg::GroupW-1:0]   fields;
   logic [7:0]                       merged [Lanes];
   logic [Lanes-1:0]                 active;
   logic [pcx_rle_pkg::GroupW-1:0]   merged_word;
   logic [pcx_rle_pkg::GroupW-1:0]   group;
   logic [3:0]                       count;
   logic                             row_last;
   logic                             image_last;
   logic                             emit;
   logic                             slot_free;
   logic                             apply_go;
   logic                             error_go;
   logic [5:0]                       reps_dec;
   logic [15:0]                      bil_inc;
   logic [16:0]                      row_inc;
   logic                             continue_run;
   logic                             req_ready;
   logic                             accept;
   logic                             start_run;
   logic                             start_literal;
   logic                             start_decode;
   logic                             start_error;

   // Position of the current byte within the line store.
   assign log_ppb   = 2'd3 - cfg.log_depth;
   assign ppb       = 4'd8 >> cfg.log_depth;
   assign col_wide  = {3'b000, bil_ff} << log_ppb;
   assign col       = col_wide[ColW-1:0];
   assign lane0     = col[2:0];
   assign word_addr = pcx_rle_pkg::RamAddrW'(col >> 3);
   assign shift     = 6'({3'b000, plane_ff} << cfg.log_depth);
   assign last_plane = (plane_ff == cfg.last_plane);
   assign fields    = pcx_rle_pkg::pixel_fields(byte_ff, cfg.log_depth);

   // Plane 0 overwrites its lanes, so a row never sees what an earlier row left.
   always_comb begin
      logic [2:0] kk;
      logic [7:0] fld;
      logic [7:0] fld_shifted;
      logic [7:0] old;
      for (int j = 0; j < Lanes; j++) begin
         kk          = 3'(j) - lane0;
         active[j]   = (3'(j) >= lane0) && ({1'b0, kk} < ppb);
         fld         = fields[kk*LaneW +: LaneW];
         fld_shifted = fld << shift[2:0];
         old         = (plane_ff == 3'd0) ? 8'd0 : ram_rdata[j*LaneW +: LaneW];
         merged[j]   = old | ((active[j] && shift < 6'd8) ? fld_shifted : 8'd0);
         merged_word[j*LaneW +: LaneW] = merged[j];
      end
   end

   always_comb begin
      logic in_row;
      group = '0;
      count = 4'd0;
      for (int k = 0; k < Lanes; k++) begin
         in_row = (4'(k) < ppb)
               && (({1'b0, col} + 14'(k)) < {1'b0, cfg.image_width});
         if (in_row) begin
            group[k*LaneW +: LaneW] = merged[3'(lane0 + 3'(k))];
            count = count + 4'd1;
         end
      end
   end

   assign row_last   = ({1'b0, col} + 14'(count)) == {1'b0, cfg.image_width};
   assign image_last = row_last && (({1'b0, row_ff} + 18'd1) == {1'b0, cfg.image_height});
   assign emit       = last_plane && (count != 4'd0);
   assign slot_free  = !out_valid_ff || rsp_if.ready;
   assign apply_go   = (state_ff == pcx_rle_pkg::ST_APPLY) && (!emit || slot_free);
   assign error_go   = (state_ff == pcx_rle_pkg::ST_ERROR) && slot_free;
   assign reps_dec   = reps_ff - 6'd1;
   assign bil_inc    = bil_ff + 16'd1;
   assign row_inc    = row_ff + 17'd1;

   // Line, plane and row position after a repetition retires.
   always_comb begin
      bil_in      = bil_ff;
      plane_in    = plane_ff;
      row_in      = row_ff;
      finished_in = finished_ff;
      if (apply_go) begin
         if (bil_inc == cfg.bytes_per_line) begin
            bil_in = 16'd0;
            if (last_plane) begin
               plane_in    = 3'd0;
               row_in      = row_inc;
               finished_in = (row_inc >= cfg.image_height);
            end else begin
               plane_in = plane_ff + 3'd1;
            end
         end else begin
            bil_in = bil_inc;
         end
      end
      if (error_go) begin
         finished_in = 1'b1;
      end
   end

   assign continue_run  = apply_go && (reps_dec != 6'd0) && !finished_in;
   assign req_ready     = (state_ff == pcx_rle_pkg::ST_IDLE) || (apply_go && !continue_run);
   assign accept        = req_if.valid && req_ready;
   assign start_error   = accept && !finished_in && cfg.setting_bad;
   assign start_run     = accept && !finished_in && !cfg.setting_bad && run_pending_ff
                          && (run_length_ff != 6'd0);
   assign start_literal = accept && !finished_in && !cfg.setting_bad && !run_pending_ff
                          && (req_if.code_byte[7:6] != pcx_rle_pkg::RunMarkerHi);
   assign start_decode  = start_run || start_literal;

   // Byte, repeat count and run marker loading.
   always_comb begin
      byte_in        = byte_ff;
      reps_in        = apply_go ? reps_dec : reps_ff;
      run_pending_in = run_pending_ff;
      run_length_in  = run_length_ff;
      if (accept && !finished_in && !cfg.setting_bad) begin
         if (run_pending_ff) begin
            run_pending_in = 1'b0;
            byte_in        = req_if.code_byte;
            reps_in        = run_length_ff;
         end else if (req_if.code_byte[7:6] == pcx_rle_pkg::RunMarkerHi) begin
            run_pending_in = 1'b1;
            run_length_in  = req_if.code_byte[5:0];
         end else begin
            byte_in = req_if.code_byte;
            reps_in = 6'd1;
         end
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pcx_rle_pkg::ST_IDLE:  state_in = pcx_rle_pkg::ST_IDLE;
         pcx_rle_pkg::ST_FETCH: state_in = pcx_rle_pkg::ST_APPLY;
         pcx_rle_pkg::ST_APPLY: begin
            if (continue_run) begin
               state_in = (plane_in == 3'd0) ? pcx_rle_pkg::ST_APPLY : pcx_rle_pkg::ST_FETCH;
            end else if (apply_go) begin
               state_in = pcx_rle_pkg::ST_IDLE;
            end
         end
         pcx_rle_pkg::ST_ERROR: begin
            if (error_go) begin
               state_in = pcx_rle_pkg::ST_IDLE;
            end
         end
      endcase
      if (start_error) begin
         state_in = pcx_rle_pkg::ST_ERROR;
      end else if (start_decode) begin
         state_in = (plane_in == 3'd0) ? pcx_rle_pkg::ST_APPLY : pcx_rle_pkg::ST_FETCH;
      end
   end

   // Result register.
   always_comb begin
      out_valid_in = out_valid_ff && !rsp_if.ready;
      out_in       = out_ff;
      if (apply_go && emit) begin
         out_valid_in        = 1'b1;
         out_in.pixel_group  = group;
         out_in.pixel_count  = count;
         out_in.row_index    = row_ff[15:0];
         out_in.first_column = col[11:0];
         out_in.row_last     = row_last;
         out_in.image_last   = image_last;
         out_in.setting_bad  = 1'b0;
      end else if (error_go) begin
         out_valid_in       = 1'b1;
         out_in             = '0;
         out_in.setting_bad = 1'b1;
      end
   end

   // Outputs.
   always_comb begin
      ram_req.rd_en    = (state_ff == pcx_rle_pkg::ST_FETCH);
      ram_req.rd_addr  = word_addr;
      ram_req.wr_en    = apply_go && !last_plane;
      ram_req.wr_lanes = active;
      ram_req.wr_addr  = word_addr;
      ram_req.wr_data  = merged_word;
      req_if.ready     = req_ready;
      status.active    = (state_ff != pcx_rle_pkg::ST_IDLE);
      status.finished  = finished_ff;
   end

   assign rsp_if.valid        = out_valid_ff;
   assign rsp_if.pixel_group  = out_ff.pixel_group;
   assign rsp_if.pixel_count  = out_ff.pixel_count;
   assign rsp_if.row_index    = out_ff.row_index;
   assign rsp_if.first_column = out_ff.first_column;
   assign rsp_if.row_last     = out_ff.row_last;
   assign rsp_if.image_last   = out_ff.image_last;
   assign rsp_if.setting_bad  = out_ff.setting_bad;

   always_ff @(posedge clock) begin
      if (reset || cfg.restart) begin
         state_ff       <= pcx_rle_pkg::ST_IDLE;
         bil_ff         <= 16'd0;
         plane_ff       <= 3'd0;
         row_ff         <= 17'd0;
         reps_ff        <= 6'd0;
         run_pending_ff <= 1'b0;
         run_length_ff  <= 6'd0;
         finished_ff    <= 1'b0;
      end else begin
         state_ff       <= state_in;
         bil_ff         <= bil_in;
         plane_ff       <= plane_in;
         row_ff         <= row_in;
         reps_ff        <= reps_in;
         run_pending_ff <= run_pending_in;
         run_length_ff  <= run_length_in;
         finished_ff    <= finished_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      out_ff  <= out_in;
   end

endmodule
`default_nettype wire
